// ===== src/kcf_pkg.sv =====
package kcf_pkg;

  typedef enum logic [1:0] {
    REG_KMER_LENGTH     = 2'd0,
    REG_WINDOW_LENGTH   = 2'd1,
    REG_CLUMP_THRESHOLD = 2'd2
  } reg_idx_e;

  localparam int unsigned CountW   = 11;
  localparam logic [CountW-1:0] CountMax = 11'd2047;
  localparam logic [3:0]  KLenReset  = 4'd9;
  localparam logic [10:0] WLenReset  = 11'd500;
  localparam logic [10:0] ThrReset   = 11'd3;

  // back-end pass over one queued symbol
  typedef enum logic [2:0] {
    BE_CLEAR,
    BE_IDLE,
    BE_OLD_RD,
    BE_OLD_WR,
    BE_NEW_RD,
    BE_NEW_WR
  } be_state_e;

endpackage

// ===== src/kcf_ram.sv =====
module kcf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/kcf_front.sv =====
// Front end: rolling k-mer, fill level and ring. Decides per symbol whether a
// k-mer leaves and whether one enters, and offers that job on the job handshake.
module kcf_front #(
  parameter int unsigned KMax = 9,
  parameter int unsigned LMax = 1024,
  parameter int unsigned CodeW = 2 * KMax,
  parameter int unsigned LenW = $clog2(LMax + 1),
  parameter int unsigned RingAw = $clog2(LMax)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              restart_i,
  input  logic [3:0]        k_i,
  input  logic [LenW-1:0]   l_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        sym_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output logic              job_old_o,
  output logic              job_new_o,
  output logic [CodeW-1:0]  job_old_code_o,
  output logic [CodeW-1:0]  job_new_code_o
);

  logic [CodeW-1:0]  roll_q, roll_d;
  logic [LenW-1:0]   seen_q, seen_d;
  logic [RingAw-1:0] ptr_q, ptr_d;
  logic [CodeW-1:0]  kmask;
  logic              take, has_old, has_new, fits;
  logic [LenW-1:0]   seen_inc;
  logic [LenW-1:0]   in_win;
  logic [RingAw-1:0] old_idx;
  logic [CodeW-1:0]  ring_rd;
  logic              hold_q, hold_d;   // a job is held for the back end
  logic              pend_old_q, pend_new_q;
  logic [CodeW-1:0]  pend_code_q;
  logic              rd_fresh_q;       // ring_rd holds the leaving code this cycle
  logic [CodeW-1:0]  old_code_q;

  always_comb begin
    for (int i = 0; i < CodeW; i++) begin
      kmask[i] = (i < 2 * k_i);
    end
  end

  assign fits    = (l_i >= LenW'(k_i));
  assign has_old = fits && (seen_q >= l_i);
  assign seen_inc = (seen_q >= l_i) ? seen_q : seen_q + LenW'(1);
  assign has_new = fits && (seen_inc >= LenW'(k_i));
  assign in_win  = l_i - LenW'(k_i) + LenW'(1);
  // ring index wraps at LMax
  assign old_idx = (LenW'(ptr_q) >= in_win) ? RingAw'(LenW'(ptr_q) - in_win) :
                   RingAw'(LenW'(ptr_q) + LenW'(LMax) - in_win);

  // one symbol in flight: the ring read is registered, then the job waits for space
  assign in_ready_o  = !hold_q && !restart_i;
  assign take        = in_valid_i && in_ready_o;
  assign job_valid_o = hold_q;
  assign job_old_o   = pend_old_q;
  assign job_new_o   = pend_new_q;
  assign job_new_code_o = pend_code_q;
  assign job_old_code_o = rd_fresh_q ? ring_rd : old_code_q;

  always_comb begin
    roll_d = roll_q;
    seen_d = seen_q;
    ptr_d  = ptr_q;
    hold_d = hold_q;
    if (take) begin
      roll_d = ((roll_q << 2) | CodeW'(sym_i)) & kmask;
      seen_d = seen_inc;
      if (has_new) ptr_d = (ptr_q == RingAw'(LMax - 1)) ? '0 : ptr_q + RingAw'(1);
      hold_d = has_old || has_new;
    end else if (hold_q && job_ready_i) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q     <= '0;
      seen_q     <= '0;
      ptr_q      <= '0;
      hold_q     <= 1'b0;
      rd_fresh_q <= 1'b0;
    end else if (restart_i) begin
      roll_q     <= '0;
      seen_q     <= '0;
      ptr_q      <= '0;
      hold_q     <= 1'b0;
      rd_fresh_q <= 1'b0;
    end else begin
      roll_q     <= roll_d;
      seen_q     <= seen_d;
      ptr_q      <= ptr_d;
      hold_q     <= hold_d;
      rd_fresh_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_old_q  <= has_old;
      pend_new_q  <= has_new;
      pend_code_q <= roll_d;
    end
    if (rd_fresh_q) old_code_q <= ring_rd;
  end

  // the leaving code is read at the accepting edge, before the entering one
  // may overwrite the same entry; it is kept in old_code_q while held
  kcf_ram #(.Width(CodeW), .Depth(LMax)) u_ring (
    .clk_i   (clk_i),
    .we_i    (take && has_new),
    .waddr_i (ptr_q),
    .wdata_i (roll_d),
    .raddr_i (old_idx),
    .rdata_o (ring_rd)
  );

endmodule

// ===== src/kcf_back.sv =====
// Back end: one table of counts with a mark bit per entry, cleared by a sweep after reset or restart.
module kcf_back #(
  parameter int unsigned CodeW = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic [10:0]      thr_i,
  output logic             busy_clear_o,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  logic             job_old_i,
  input  logic             job_new_i,
  input  logic [CodeW-1:0] job_old_code_i,
  input  logic [CodeW-1:0] job_new_code_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [CodeW-1:0] res_code_o
);

  localparam int unsigned EntW = kcf_pkg::CountW + 1;

  kcf_pkg::be_state_e st_q, st_d;
  logic [CodeW-1:0] clr_q, clr_d;
  logic             n_q;
  logic [CodeW-1:0] oc_q, nc_q;
  logic             lat;
  logic             we;
  logic [CodeW-1:0] waddr, raddr;
  logic [EntW-1:0]  wdata, rdata;
  logic [kcf_pkg::CountW-1:0] cnt;
  logic [kcf_pkg::CountW-1:0] thr;
  logic             hit;
  logic             rv_q, rv_d;
  logic [CodeW-1:0] rc_q;

  assign thr = (thr_i == '0) ? 11'd1 : thr_i;
  assign cnt = rdata[kcf_pkg::CountW-1:0];
  // a saturated count stays at the top and still meets any threshold
  assign hit = ((cnt == kcf_pkg::CountMax) || (cnt + 11'd1 >= thr)) && !rdata[EntW-1];
  assign busy_clear_o = (st_q == kcf_pkg::BE_CLEAR);
  assign res_valid_o = rv_q;
  assign res_code_o  = rc_q;

  always_comb begin
    st_d = st_q;
    clr_d = clr_q;
    lat = 1'b0;
    we = 1'b0;
    waddr = oc_q;
    wdata = rdata;
    raddr = oc_q;
    rv_d = rv_q && !res_ready_i;
    job_ready_o = 1'b0;
    case (st_q)
      kcf_pkg::BE_CLEAR: begin
        we = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + CodeW'(1);
        if (clr_q == '1) st_d = kcf_pkg::BE_IDLE;
      end
      kcf_pkg::BE_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          lat = 1'b1;
          if (job_old_i) begin
            raddr = job_old_code_i;
            st_d = kcf_pkg::BE_OLD_RD;
          end else begin
            raddr = job_new_code_i;
            st_d = kcf_pkg::BE_NEW_RD;
          end
        end
      end
      kcf_pkg::BE_OLD_RD: st_d = kcf_pkg::BE_OLD_WR;
      kcf_pkg::BE_OLD_WR: begin
        we = 1'b1;
        waddr = oc_q;
        wdata = {rdata[EntW-1], (cnt == '0) ? cnt : cnt - 11'd1};
        raddr = nc_q;
        st_d = n_q ? kcf_pkg::BE_NEW_RD : kcf_pkg::BE_IDLE;
      end
      kcf_pkg::BE_NEW_RD: begin
        raddr = nc_q;
        st_d = kcf_pkg::BE_NEW_WR;
      end
      kcf_pkg::BE_NEW_WR: begin
        raddr = nc_q;
        if (!rv_q || res_ready_i) begin
          we = 1'b1;
          waddr = nc_q;
          wdata = {rdata[EntW-1] | hit,
                   (cnt == kcf_pkg::CountMax) ? cnt : cnt + 11'd1};
          rv_d = hit;
          st_d = kcf_pkg::BE_IDLE;
        end
      end
      default: st_d = kcf_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= kcf_pkg::BE_CLEAR;
      clr_q <= '0;
      rv_q  <= 1'b0;
    end else if (restart_i) begin
      st_q  <= kcf_pkg::BE_CLEAR;
      clr_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      rv_q  <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lat) begin
      n_q  <= job_new_i;
      oc_q <= job_old_code_i;
      nc_q <= job_new_code_i;
    end
    if (st_q == kcf_pkg::BE_NEW_WR && we && hit) rc_q <= nc_q;
  end

  kcf_ram #(.Width(EntW), .Depth(2 ** CodeW)) u_cnt (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ===== src/kmer_clump_finder.sv =====
// Each result follows the entering count update of its word, and once the
// window is full the leaving update comes first. Throughput: one word per
// cycle before a k-mer fits; later the next word is taken while the back end
// works on the last, and a result held by m_axis_tready low stalls the next
// entering update. Reset (rst_ni low, async) and any write to a known register
// clear all control state and sweep all 2^(2*K_MAX) table entries; no word taken.
module kmer_clump_finder #(
  parameter int unsigned K_MAX = 9,
  parameter int unsigned L_MAX = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [1:0] nucleotide
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [((2*K_MAX+7)/8)*8-1:0] m_axis_tdata,  // [2K-1:0] kmer_code
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [10:0]          cfg_data_i
);

  localparam int unsigned CodeW = 2 * K_MAX;
  localparam int unsigned LenW  = $clog2(L_MAX + 1);

  logic [3:0]  k_q;
  logic [10:0] l_q, thr_q;
  logic [3:0]  k_eff;
  logic [LenW-1:0] l_eff;
  logic        restart;
  logic        clearing;
  logic        in_ready;
  logic        jv, jr, jo, jn;
  logic [CodeW-1:0] joc, jnc, rc;

  // any write to a known register restarts the stream
  assign restart = cfg_we_i && (cfg_idx_i == kcf_pkg::REG_KMER_LENGTH ||
                                cfg_idx_i == kcf_pkg::REG_WINDOW_LENGTH ||
                                cfg_idx_i == kcf_pkg::REG_CLUMP_THRESHOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= kcf_pkg::KLenReset;
      l_q   <= kcf_pkg::WLenReset;
      thr_q <= kcf_pkg::ThrReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kcf_pkg::REG_KMER_LENGTH:     k_q   <= cfg_data_i[3:0];
        kcf_pkg::REG_WINDOW_LENGTH:   l_q   <= cfg_data_i;
        kcf_pkg::REG_CLUMP_THRESHOLD: thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp k to 1..K_MAX, L to 1..L_MAX
  assign k_eff = (k_q == '0) ? 4'd1 : (k_q > 4'(K_MAX)) ? 4'(K_MAX) : k_q;
  assign l_eff = (l_q == '0) ? LenW'(1) :
                 (32'(l_q) > L_MAX) ? LenW'(L_MAX) : LenW'(l_q);

  assign s_axis_tready = in_ready && !clearing;

  kcf_front #(.KMax(K_MAX), .LMax(L_MAX)) u_front (
    .clk_i, .rst_ni,
    .restart_i      (restart),
    .k_i            (k_eff),
    .l_i            (l_eff),
    .in_valid_i     (s_axis_tvalid && !clearing),
    .in_ready_o     (in_ready),
    .sym_i          (s_axis_tdata[1:0]),
    .job_valid_o    (jv),
    .job_ready_i    (jr),
    .job_old_o      (jo),
    .job_new_o      (jn),
    .job_old_code_o (joc),
    .job_new_code_o (jnc)
  );

  kcf_back #(.CodeW(CodeW)) u_back (
    .clk_i, .rst_ni,
    .restart_i      (restart),
    .thr_i          (thr_q),
    .busy_clear_o   (clearing),
    .job_valid_i    (jv),
    .job_ready_o    (jr),
    .job_old_i      (jo),
    .job_new_i      (jn),
    .job_old_code_i (joc),
    .job_new_code_i (jnc),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_code_o     (rc)
  );

  assign m_axis_tdata = (($bits(m_axis_tdata)))'(rc);

endmodule

// ===== src/kcf_checker.sv =====
module kcf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic       cfg_we_i,
  input logic [1:0] cfg_idx_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && !cfg_we_i |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i <= kcf_pkg::REG_CLUMP_THRESHOLD) |=> !s_axis_tready)
    else $error("input taken during table clear");

  a_cfg_kills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i <= kcf_pkg::REG_CLUMP_THRESHOLD) |=> !m_axis_tvalid)
    else $error("result survived restart");

endmodule

bind kmer_clump_finder kcf_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .cfg_we_i, .cfg_idx_i
);

// ===== tb/kmer_clump_finder_tb.sv =====
module kmer_clump_finder_tb;

  localparam int unsigned KMax      = 9;
  localparam int unsigned LMax      = 1024;
  localparam int unsigned KmerSpace = 1 << (2 * KMax);
  localparam int unsigned DataW     = ((2 * KMax + 7) / 8) * 8;
  // index past the last register: must leave the stream alone
  localparam logic [1:0] RegUnused  = 2'd3;
  localparam int unsigned HangLimit = 1000000;  // > one table sweep of 2^18 entries
  localparam int unsigned HoldLen   = 300;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;   // [1:0] nucleotide
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;        // [17:0] kmer_code
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = '0;
  logic [10:0]      cfg_data_i = '0;

  kmer_clump_finder #(.K_MAX(KMax), .L_MAX(LMax)) uut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Clump predictor: its own copy of registers and window state
  // ---------------------------------------------------------------------------
  logic [3:0]      klen_q;
  logic [10:0]     wlen_q;
  logic [10:0]     thr_q;
  logic [17:0]     roll_kmer;
  int unsigned     seen_cnt;
  int unsigned     ring_ptr;
  logic [17:0]     ring_kmers [LMax];
  logic [10:0]     occ_cnt [KmerSpace];
  bit              reported [KmerSpace];
  logic [17:0]     clump_q [$];

  int unsigned     err_cnt;
  bit              idle_en;    // random gaps on both sides
  bit              hold_req;   // ask the receiver for one long hold-off
  int unsigned     quiet_cycles;

  task automatic stream_restart();
    roll_kmer = '0;
    seen_cnt  = 0;
    ring_ptr  = 0;
    foreach (ring_kmers[i]) ring_kmers[i] = '0;
    foreach (occ_cnt[i]) occ_cnt[i] = '0;
    foreach (reported[i]) reported[i] = 1'b0;
  endtask

  // advance the window by one symbol, queue a newly found clump
  task automatic clump_predict(input logic [1:0] sym);
    int unsigned k, l, t, span, old_idx;
    logic [31:0] kmask;
    logic [17:0] code, old_code;
    k = (klen_q == 0) ? 1 : (klen_q > KMax) ? KMax : klen_q;
    l = (wlen_q == 0) ? 1 : (wlen_q > LMax) ? LMax : wlen_q;
    t = (thr_q == 0) ? 1 : thr_q;
    kmask = (32'd1 << (2 * k)) - 1;
    roll_kmer = 18'(((32'(roll_kmer) << 2) | sym) & kmask);
    if (l < k) begin
      if (seen_cnt < l) seen_cnt++;
      return;
    end
    if (seen_cnt >= l) begin
      // oldest k-mer drops out of the window
      span = l - k + 1;
      old_idx = (ring_ptr + LMax - span) % LMax;
      old_code = ring_kmers[old_idx];
      if (occ_cnt[old_code] > 0) occ_cnt[old_code]--;
    end else begin
      seen_cnt++;
    end
    if (seen_cnt < k) return;
    code = roll_kmer;
    ring_kmers[ring_ptr] = code;
    ring_ptr = (ring_ptr + 1) % LMax;
    if (occ_cnt[code] < kcf_pkg::CountMax) occ_cnt[code]++;
    if (occ_cnt[code] >= t && !reported[code]) begin
      reported[code] = 1'b1;
      clump_q = {clump_q, code};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: follows both handshakes and the config port at each edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles <= ((s_axis_tvalid && s_axis_tready) ||
                       (m_axis_tvalid && m_axis_tready)) ? 0 : quiet_cycles + 1;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kcf_pkg::REG_KMER_LENGTH:     klen_q = cfg_data_i[3:0];
          kcf_pkg::REG_WINDOW_LENGTH:   wlen_q = cfg_data_i;
          kcf_pkg::REG_CLUMP_THRESHOLD: thr_q  = cfg_data_i;
          default: ;
        endcase
        if (cfg_idx_i != RegUnused) stream_restart();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        clump_predict(s_axis_tdata[1:0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (clump_q.size() == 0) begin
          $error("unexpected word: kmer_code actual %0h", m_axis_tdata[17:0]);
          err_cnt++;
        end else if (m_axis_tdata[17:0] !== clump_q[0]) begin
          $error("kmer_code mismatch: expected %0h actual %0h",
                 clump_q[0], m_axis_tdata[17:0]);
          err_cnt++;
          void'(clump_q.pop_front());
        end else begin
          void'(clump_q.pop_front());
        end
      end
    end
  end

  // watchdog: nothing accepted on either side for too long
  always @(posedge clk_i) begin
    if (quiet_cycles >= HangLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldLen) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [1:0] sym);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, sym};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // random symbols mixed with repeated short motifs, so clumps form
  task automatic send_mixed(input int unsigned n);
    logic [1:0] motif [6];
    int unsigned mlen, sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 1)) begin
        repeat (10) begin
          if (sent < n) begin
            send_word(2'($urandom));
            sent++;
          end
        end
      end else begin
        mlen = $urandom_range(1, 6);
        foreach (motif[i]) motif[i] = 2'($urandom);
        repeat ($urandom_range(2, 5))
          for (int i = 0; i < mlen && sent < n; i++) begin
            send_word(motif[i]);
            sent++;
          end
      end
    end
  endtask

  // drain results and let the back end settle before a config write
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (clump_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] k, input logic [10:0] l, input logic [10:0] t);
    wait_drained();
    write_reg(kcf_pkg::REG_KMER_LENGTH, 11'(k));
    write_reg(kcf_pkg::REG_WINDOW_LENGTH, l);
    write_reg(kcf_pkg::REG_CLUMP_THRESHOLD, t);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset defaults (k=9, L=500, t=3): a period-4 pattern repeats each 9-mer
  task automatic test_reset_defaults();
    logic [1:0] pat [4] = '{2'd0, 2'd1, 2'd2, 2'd3};
    for (int i = 0; i < 24; i++) send_word(pat[i % 4]);
  endtask

  // out-of-range low k and t, oversized L: every new 1-mer is a clump
  task automatic test_extreme_low();
    set_config(4'd0, 11'd2047, 11'd0);
    for (int i = 0; i < 8; i++) send_word(2'(i));
    send_mixed(90);
  endtask

  // window shorter than the k-mer: nothing counted; then an unused index
  // is written and must not disturb the stream
  task automatic test_short_window();
    set_config(4'd15, 11'd5, 11'd2047);
    send_mixed(20);
    wait_drained();
    write_reg(RegUnused, 11'h7ff);
    send_mixed(10);
  endtask

  // sliding window with evictions; one long receiver hold-off mid-run
  task automatic test_sliding_window();
    set_config(4'd2, 11'd20, 11'd2);
    send_mixed(100);
    hold_req = 1'b1;
    send_mixed(60);
    // one-symbol window with full-length k: nothing ever fits
    set_config(4'd9, 11'd1, 11'd1);
    send_mixed(40);
    set_config(4'd3, 11'd12, 11'd3);
    send_mixed(60);
    idle_en = 1'b0;
    send_mixed(40);
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    int unsigned wait_cnt;
    err_cnt = 0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    quiet_cycles = 0;
    klen_q = kcf_pkg::KLenReset;
    wlen_q = kcf_pkg::WLenReset;
    thr_q  = kcf_pkg::ThrReset;
    stream_restart();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_extreme_low();
    test_short_window();
    test_sliding_window();

    wait_cnt = 0;
    while (clump_q.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (clump_q.size() != 0) begin
      $error("%0d expected kmer_code words never arrived", clump_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/kcf_pkg.sv
src/kcf_ram.sv
src/kcf_front.sv
src/kcf_back.sv
src/kmer_clump_finder.sv
src/kcf_checker.sv
tb/kmer_clump_finder_tb.sv
